>>> rtl/rplb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rplb_pkg
// shared types, codes and constants of the ring partition load balancer
// ---------------------------------------------------------------------------
package rplb_pkg;

  localparam int NODES_DEF     = 64;
  localparam int LOAD_BITS_DEF = 32;
  localparam int NODE_W        = 6;
  localparam int OUT_W         = 32;
  localparam int COEF_W        = 16;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 104;

  localparam logic [COEF_W-1:0] ALPHA_RST = 16'd1399;
  localparam logic [COEF_W-1:0] BETA_RST  = 16'd1050;
  localparam logic [COEF_W-1:0] ONE_Q     = 16'd256;
  localparam logic [COEF_W-1:0] TWO_Q     = 16'd512;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_BETA  = 1'b1;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_REM = 1'b1;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_MIN_SPLIT = 3'd1;
  localparam logic [2:0] ACT_EVEN      = 3'd2;
  localparam logic [2:0] ACT_MAX_SPLIT = 3'd3;
  localparam logic [2:0] ACT_REJECT    = 3'd4;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHK, S_SCAN, S_SCAN_END, S_EVAL, S_CMP1, S_RD_P, S_RD_N,
    S_NB, S_CMP2, S_EVEN, S_SPLIT_RD, S_SPLIT_V, S_SH_RD, S_SH_WR, S_WR_LO,
    S_WR_HI, S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic gt;
  } cmp_res_t;

endpackage

>>> rtl/ring_partition_load_balancer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ring_partition_load_balancer
// key counts of a ring of partitions with add/remove driven rebalancing
// ---------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_tvalid/in_tready  in_tdata: cmd, node
// out      out  out_tvalid/out_tready out_tdata: action, keys_moved, max, min
// cfg      in   cfg_wr_en            cfg_index, cfg_wdata
//
// request: a request is served by up to two ring scans over the single read
//   port of the load memory, the shift of up to NODES-2 entries with one read
//   and one write each, and the shift-add threshold compare
// reset: a clearing pass over all NODES entries zeroes the load memory, no request
//   is taken meanwhile; configuration writes are taken at any time
// stalls: one request at a time; a finished result waits in the output
//   register while the block returns to idle and takes the next request
// ---------------------------------------------------------------------------
module ring_partition_load_balancer #(
  parameter int NODES     = rplb_pkg::NODES_DEF,
  parameter int LOAD_BITS = rplb_pkg::LOAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // cmd [0], node [6:1]
  input  logic [rplb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action [2:0], keys_moved [34:3], max_load [66:35], min_load [98:67]
  output logic [rplb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [rplb_pkg::COEF_W-1:0]       cfg_wdata
);
  import rplb_pkg::*;

  localparam int NB  = $clog2(NODES);
  localparam int LW  = LOAD_BITS;
  localparam int NCW = ((NB > NODE_W) ? NB : NODE_W) + 1;
  localparam logic [NB-1:0] LAST = NB'(NODES - 1);

  // configuration
  logic [COEF_W-1:0] alpha_q_r, beta_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_q_r <= ALPHA_RST;
      beta_q_r  <= BETA_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_ALPHA) begin
        alpha_q_r <= cfg_wdata;
      end else begin
        beta_q_r <= cfg_wdata;
      end
    end
  end

  // sequencer state
  state_t        state_r, state_nxt;
  logic [NB-1:0] cnt_r, cnt_nxt;
  logic          ph_r, ph_nxt;           // 1: closing scan
  logic          cmd_r, cmd_nxt;
  logic [NB-1:0] node_r, node_nxt;
  logic [NB-1:0] c_r, c_nxt;             // center whose neighbors are read
  logic [NB-1:0] nb_r, nb_nxt;
  logic [NB-1:0] r_r, r_nxt;             // entry that leaves the ring
  logic [NB-1:0] s_r, s_nxt;             // entry that splits
  logic [NB-1:0] j_r, j_nxt;
  logic [LW-1:0] lv_r, lv_nxt;
  logic [LW-1:0] pv_r, pv_nxt;
  logic [LW-1:0] nbv_r, nbv_nxt;
  logic [LW-1:0] lower_r, lower_nxt;
  logic [LW-1:0] upper_r, upper_nxt;
  logic [LW-1:0] moved_r, moved_nxt;
  logic [2:0]    act_r, act_nxt;
  logic          sv_r, sv_nxt;
  logic [NB-1:0] sidx_r, sidx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] od_r, od_nxt;

  // memory and units
  logic          mem_we;
  logic [NB-1:0] mem_waddr, mem_raddr;
  logic [LW-1:0] mem_wdata, mem_rdata;
  logic          cmp_start;
  logic [LW-1:0] cmp_a, cmp_b;
  logic [COEF_W-1:0] cmp_ca, cmp_cb;
  cmp_res_t      cmp_res;
  logic [LW-1:0] min_val, max_val;
  logic [NB-1:0] min_idx, max_idx;

  rplb_mem #(.DEPTH(NODES), .WIDTH(LW), .AW(NB)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  rplb_cmp #(.LW(LW)) u_cmp (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmp_start),
    .a    (cmp_a),
    .ca   (cmp_ca),
    .b    (cmp_b),
    .cb   (cmp_cb),
    .res  (cmp_res)
  );

  rplb_scan #(.LW(LW), .NB(NB)) u_scan (
    .clk    (clk),
    .vld    (sv_r),
    .idx    (sidx_r),
    .data   (mem_rdata),
    .min_val(min_val),
    .min_idx(min_idx),
    .max_val(max_val),
    .max_idx(max_idx)
  );

  // ring neighbors of the center
  logic [NB-1:0] c_prev, c_next;
  assign c_prev = (c_r == '0) ? LAST : c_r - 1'b1;
  assign c_next = (c_r == LAST) ? '0 : c_r + 1'b1;

  // shift direction and final slot of the lower half
  logic          lt_rs;
  logic [NB-1:0] lo_pos;
  assign lt_rs  = r_r < s_r;
  assign lo_pos = lt_rs ? s_r - 1'b1 : s_r;

  logic          in_oor;
  logic          in_cmd;
  assign in_cmd = in_tdata[0];
  assign in_oor = NCW'(in_tdata[NODE_W:1]) >= NCW'(NODES);
  assign in_tready = (state_r == S_IDLE);

  // scratch values
  logic          lighter_prev;
  logic [NB-1:0] nb_sel;
  logic [LW-1:0] nbv_sel;
  logic [LW:0]   sum_w;
  logic [LW-1:0] base_w, hi_w, lo_w, fl_w, ce_w;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    cmd_nxt   = cmd_r;
    node_nxt  = node_r;
    c_nxt     = c_r;
    nb_nxt    = nb_r;
    r_nxt     = r_r;
    s_nxt     = s_r;
    j_nxt     = j_r;
    lv_nxt    = lv_r;
    pv_nxt    = pv_r;
    nbv_nxt   = nbv_r;
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    moved_nxt = moved_r;
    act_nxt   = act_r;
    sv_nxt    = 1'b0;
    sidx_nxt  = cnt_r;
    od_nxt    = od_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = '0;
    mem_raddr = cnt_r;
    cmp_start = 1'b0;
    cmp_a     = lv_r;
    cmp_b     = max_val;
    cmp_ca    = beta_q_r;
    cmp_cb    = ONE_Q;
    lighter_prev = pv_r < mem_rdata;
    nb_sel    = lighter_prev ? c_prev : c_next;
    nbv_sel   = lighter_prev ? pv_r : mem_rdata;
    sum_w     = {1'b0, nbv_r} + {1'b0, lv_r};
    base_w    = (nbv_r >> 1) + (lv_r >> 1);
    hi_w      = base_w + LW'((nbv_r[0] | lv_r[0]));
    lo_w      = base_w + LW'((nbv_r[0] & lv_r[0]));
    fl_w      = mem_rdata >> 1;
    ce_w      = mem_rdata - fl_w;

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        mem_raddr = NB'(in_tdata[NODE_W:1]);
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          node_nxt  = NB'(in_tdata[NODE_W:1]);
          moved_nxt = '0;
          cnt_nxt   = '0;
          if (in_oor) begin
            act_nxt   = ACT_REJECT;
            ph_nxt    = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if ((cmd_r == CMD_ADD && (&mem_rdata)) ||
            (cmd_r == CMD_REM && mem_rdata == '0)) begin
          act_nxt = ACT_REJECT;
          ph_nxt  = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = node_r;
          mem_wdata = (cmd_r == CMD_ADD) ? mem_rdata + 1'b1 : mem_rdata - 1'b1;
          lv_nxt    = mem_wdata;
          act_nxt   = ACT_NONE;
          ph_nxt    = 1'b0;
        end
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        sv_nxt = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN_END: begin
        state_nxt = ph_r ? S_OUT : S_EVAL;
      end
      S_EVAL: begin
        if (cmd_r == CMD_ADD) begin
          c_nxt = min_idx;
          if (min_idx != node_r) begin
            cmp_start = 1'b1;
            cmp_ca    = ONE_Q;
            cmp_b     = min_val;
            cmp_cb    = alpha_q_r;
            state_nxt = S_CMP1;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          c_nxt     = node_r;
          cmp_start = 1'b1;
          state_nxt = S_CMP1;
        end
      end
      S_CMP1: begin
        if (cmp_res.done) begin
          if ((cmd_r == CMD_ADD) ? cmp_res.gt : !cmp_res.gt) begin
            state_nxt = S_RD_P;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD_P: begin
        mem_raddr = c_prev;
        state_nxt = S_RD_N;
      end
      S_RD_N: begin
        pv_nxt    = mem_rdata;
        mem_raddr = c_next;
        state_nxt = S_NB;
      end
      S_NB: begin
        nb_nxt  = nb_sel;
        nbv_nxt = nbv_sel;
        if (cmd_r == CMD_ADD) begin
          sum_w = {1'b0, nbv_sel} + {1'b0, min_val};
          if (!sum_w[LW]) begin
            mem_we    = 1'b1;
            mem_waddr = nb_sel;
            mem_wdata = sum_w[LW-1:0];
            r_nxt     = min_idx;
            s_nxt     = node_r;
            state_nxt = S_SPLIT_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          cmp_start = 1'b1;
          cmp_a     = nbv_sel;
          cmp_cb    = TWO_Q;
          state_nxt = S_CMP2;
        end
      end
      S_CMP2: begin
        if (cmp_res.done) begin
          if (cmp_res.gt) begin
            mem_we    = 1'b1;
            mem_waddr = nb_r;
            mem_wdata = hi_w;
            lower_nxt = lo_w;
            moved_nxt = (nbv_r > hi_w) ? nbv_r - hi_w : hi_w - nbv_r;
            act_nxt   = ACT_EVEN;
            state_nxt = S_EVEN;
          end else if (max_idx != node_r && !sum_w[LW]) begin
            mem_we    = 1'b1;
            mem_waddr = nb_r;
            mem_wdata = sum_w[LW-1:0];
            r_nxt     = node_r;
            s_nxt     = max_idx;
            state_nxt = S_SPLIT_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_EVEN: begin
        mem_we    = 1'b1;
        mem_waddr = node_r;
        mem_wdata = lower_r;
        ph_nxt    = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SPLIT_RD: begin
        mem_raddr = s_r;
        state_nxt = S_SPLIT_V;
      end
      S_SPLIT_V: begin
        // add puts the ceiling half first, remove the floor half
        lower_nxt = (cmd_r == CMD_ADD) ? ce_w : fl_w;
        upper_nxt = (cmd_r == CMD_ADD) ? fl_w : ce_w;
        moved_nxt = lower_nxt;
        act_nxt   = (cmd_r == CMD_ADD) ? ACT_MIN_SPLIT : ACT_MAX_SPLIT;
        j_nxt     = r_r;
        state_nxt = S_SH_RD;
      end
      S_SH_RD: begin
        if (lt_rs ? (j_r == s_r - 1'b1) : (j_r == s_r + 1'b1)) begin
          state_nxt = S_WR_LO;
        end else begin
          mem_raddr = lt_rs ? j_r + 1'b1 : j_r - 1'b1;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = mem_rdata;
        j_nxt     = lt_rs ? j_r + 1'b1 : j_r - 1'b1;
        state_nxt = S_SH_RD;
      end
      S_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_pos;
        mem_wdata = lower_r;
        state_nxt = S_WR_HI;
      end
      S_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = lo_pos + 1'b1;
        mem_wdata = upper_r;
        ph_nxt    = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          od_nxt = {5'b0, OUT_W'(min_val), OUT_W'(max_val), OUT_W'(moved_r), act_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sv_r        <= sv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r    <= ph_nxt;
    cmd_r   <= cmd_nxt;
    node_r  <= node_nxt;
    c_r     <= c_nxt;
    nb_r    <= nb_nxt;
    r_r     <= r_nxt;
    s_r     <= s_nxt;
    j_r     <= j_nxt;
    lv_r    <= lv_nxt;
    pv_r    <= pv_nxt;
    nbv_r   <= nbv_nxt;
    lower_r <= lower_nxt;
    upper_r <= upper_nxt;
    moved_r <= moved_nxt;
    act_r   <= act_nxt;
    sidx_r  <= sidx_nxt;
    od_r    <= od_nxt;
  end

  assign out_tdata  = od_r;
  assign out_tvalid = out_valid_r;

  // no memory write while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we)
    else $error("load memory written while idle");

  // the compare unit is started only when it is free
  a_cmp_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_start |-> !cmp_res.busy)
    else $error("compare started while busy");

  // a result leaving the sequencer lands in the output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || out_tready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded");

endmodule

>>> rtl/rplb_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rplb_mem
// load store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module rplb_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rplb_cmp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rplb_cmp
// shift-add compare of a*ca against b*cb, one coefficient bit per cycle
// ---------------------------------------------------------------------------
module rplb_cmp #(
  parameter int LW = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [LW-1:0]           a,
  input  logic [rplb_pkg::COEF_W-1:0] ca,
  input  logic [LW-1:0]           b,
  input  logic [rplb_pkg::COEF_W-1:0] cb,
  output rplb_pkg::cmp_res_t      res
);
  import rplb_pkg::*;

  localparam int PW    = LW + COEF_W;
  localparam int CNT_W = $clog2(COEF_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(COEF_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PW-1:0]    pa_r, pb_r, acc_a_r, acc_b_r;
  logic [COEF_W-1:0] ca_r, cb_r;
  logic             step;

  assign step = busy_r && (cnt_r != STEPS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == STEPS) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pa_r    <= PW'(a);
      pb_r    <= PW'(b);
      ca_r    <= ca;
      cb_r    <= cb;
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (step) begin
      if (ca_r[0]) begin
        acc_a_r <= acc_a_r + pa_r;
      end
      if (cb_r[0]) begin
        acc_b_r <= acc_b_r + pb_r;
      end
      pa_r <= pa_r << 1;
      pb_r <= pb_r << 1;
      ca_r <= ca_r >> 1;
      cb_r <= cb_r >> 1;
    end
  end

  assign res.busy = busy_r;
  assign res.done = busy_r && (cnt_r == STEPS);
  assign res.gt   = acc_a_r > acc_b_r;

endmodule

>>> rtl/rplb_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rplb_scan
// tracks first minimum and first maximum over a stream of ring loads
// ---------------------------------------------------------------------------
module rplb_scan #(
  parameter int LW = 32,
  parameter int NB = 6
) (
  input  logic          clk,
  input  logic          vld,
  input  logic [NB-1:0] idx,
  input  logic [LW-1:0] data,
  output logic [LW-1:0] min_val,
  output logic [NB-1:0] min_idx,
  output logic [LW-1:0] max_val,
  output logic [NB-1:0] max_idx
);

  logic [LW-1:0] min_val_r, max_val_r;
  logic [NB-1:0] min_idx_r, max_idx_r;
  logic          first;

  assign first = (idx == '0);

  always_ff @(posedge clk) begin
    if (vld) begin
      if (first || (data < min_val_r)) begin
        min_val_r <= data;
        min_idx_r <= idx;
      end
      if (first || (data > max_val_r)) begin
        max_val_r <= data;
        max_idx_r <= idx;
      end
    end
  end

  assign min_val = min_val_r;
  assign min_idx = min_idx_r;
  assign max_val = max_val_r;
  assign max_idx = max_idx_r;

endmodule
